// ===== sv/slxfr_pkg.sv =====
// ---------------------------------------------------------------------------
// slxfr_pkg
// shared types and constants of the sync/length/xor frame receiver
// ---------------------------------------------------------------------------
`default_nettype none

package slxfr_pkg;

  // result item status codes
  typedef enum logic [1:0] {
    STATUS_PAYLOAD = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_ERROR   = 2'd2
  } status_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LENGTH  = 2'd2;

  // register reset values
  localparam logic [7:0] SYNC_FIRST_RST  = 8'h4C;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h4D;
  localparam logic [6:0] MAX_LENGTH_RST  = 7'd40;

  // width of the length limit compare (store depth reaches 256)
  localparam int LIMIT_W = 9;

  // controller to datapath commands
  typedef struct packed {
    logic load_len;     // length byte: latch payload length, clear count
    logic store_byte;   // payload byte: write store, fold into xor (not the first)
    logic put_error;    // load checksum error item
    logic put_empty;    // load empty frame item
    logic start_emit;   // clear emit index
    logic rd_en;        // read store at emit index
    logic put_payload;  // load payload item from store read data
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sync1_match;
    logic sync2_match;
    logic len_ok;
    logic at_check;
    logic check_ok;
    logic plen_zero;
    logic emit_last;
    logic out_full;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/sync_length_xor_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// sync_length_xor_frame_receiver
// byte stream frame receiver: two sync bytes, length byte, payload, xor check
// ---------------------------------------------------------------------------
// Bytes enter on the rx channel, one per transfer. Every byte of the sync,
// length and payload phases is taken without a stall, so the block keeps up
// with any byte stream there. On the check byte of a good frame with P stored
// payload bytes, the block closes the rx channel and plays the payload out of
// its store: for each result the store is read, then the read data is loaded
// into the result register, and each load waits while the item channel is
// stalled. Error and empty-frame results are loaded straight from the check
// byte into the result register. The result register lets the next rx byte
// be taken while the last result still waits to be transferred. The store
// needs no clearing after reset: only bytes written in the current frame are
// ever read.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_length_xor_frame_receiver import slxfr_pkg::*; #(
  parameter int PAYLOAD_DEPTH = 64  // payload store depth, 2 to 256
) (
  input  wire logic       clk,
  input  wire logic       rst,

  // configuration write port
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,

  // received byte channel
  input  wire logic       rx_valid,
  output      logic       rx_stall,
  input  wire logic [7:0] rx_byte,

  // result item channel
  output      logic       item_valid,
  input  wire logic       item_stall,
  output      logic [1:0] status,
  output      logic [7:0] data_byte,
  output      logic [5:0] byte_index,
  output      logic       last
);

  // command and status between controller and datapath
  cmd_t  cmd;
  stat_t st;

  // controller: sync hunt, length check, body, playout sequencing
  slxfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: config registers, running xor, payload store, result register
  slxfr_dp #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .st         (st),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .data_byte  (data_byte),
    .byte_index (byte_index),
    .last       (last)
  );

endmodule

`default_nettype wire

// ===== sv/slxfr_ram.sv =====
// ---------------------------------------------------------------------------
// slxfr_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module slxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/slxfr_dp.sv =====
// ---------------------------------------------------------------------------
// slxfr_dp
// datapath: config registers, length/count/xor, payload store, result register
// ---------------------------------------------------------------------------
`default_nettype none

module slxfr_dp import slxfr_pkg::*; #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic [7:0] rx_byte,
  input  wire cmd_t       cmd,
  output      stat_t      st,
  output      logic       item_valid,
  input  wire logic       item_stall,
  output      logic [1:0] status,
  output      logic [7:0] data_byte,
  output      logic [5:0] byte_index,
  output      logic       last
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  logic [7:0]         sync_first;
  logic [7:0]         sync_second;
  logic [6:0]         max_length;
  logic [AW-1:0]      plen;
  logic [AW-1:0]      count;
  logic [7:0]         xacc;
  logic [AW-1:0]      eidx;
  logic [7:0]         ram_rdata;
  logic [LIMIT_W-1:0] limit;
  logic [15:0]        eidx_wide;
  logic               eidx_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      max_length  <= MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        CFG_MAX_LENGTH:  max_length  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // length limit is the smaller of max_length and the store depth
  always_comb begin
    if (LIMIT_W'(max_length) > LIMIT_W'(PAYLOAD_DEPTH)) begin
      limit = LIMIT_W'(PAYLOAD_DEPTH);
    end else begin
      limit = LIMIT_W'(max_length);
    end
  end

  assign eidx_last = (eidx == plen - AW'(1));
  assign eidx_wide = 16'(eidx);

  assign st.sync1_match = (rx_byte == sync_first);
  assign st.sync2_match = (rx_byte == sync_second);
  assign st.len_ok      = (LIMIT_W'(rx_byte) <= limit);
  assign st.at_check    = (count == plen);
  assign st.check_ok    = (rx_byte == xacc);
  assign st.plen_zero   = (plen == '0);
  assign st.emit_last   = eidx_last;
  assign st.out_full    = item_valid && item_stall;

  // frame length, receive count and running xor
  always_ff @(posedge clk) begin
    if (rst) begin
      plen  <= '0;
      count <= '0;
      xacc  <= '0;
    end else if (cmd.load_len) begin
      // accepted lengths never exceed the depth, so length-1 fits
      plen  <= (rx_byte == 8'd0) ? '0 : AW'(rx_byte - 8'd1);
      count <= '0;
      xacc  <= '0;
    end else if (cmd.store_byte) begin
      count <= count + AW'(1);
      if (count != '0) begin
        xacc <= xacc ^ rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eidx <= '0;
    end else if (cmd.start_emit) begin
      eidx <= '0;
    end else if (cmd.put_payload) begin
      eidx <= eidx + AW'(1);
    end
  end

  slxfr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (count),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (eidx),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.put_error || cmd.put_empty || cmd.put_payload) begin
      item_valid <= 1'b1;
    end else if (!item_stall) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_error) begin
      status     <= STATUS_ERROR;
      data_byte  <= '0;
      byte_index <= '0;
      last       <= 1'b1;
    end else if (cmd.put_empty) begin
      status     <= STATUS_EMPTY;
      data_byte  <= '0;
      byte_index <= '0;
      last       <= 1'b1;
    end else if (cmd.put_payload) begin
      status     <= STATUS_PAYLOAD;
      data_byte  <= ram_rdata;
      byte_index <= eidx_wide[5:0];
      last       <= eidx_last;
    end
  end

  // a loaded result must never overwrite one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.put_error || cmd.put_empty || cmd.put_payload) |-> !(item_valid && item_stall))
    else $error("result register overwritten while stalled");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.put_error, cmd.put_empty, cmd.put_payload}))
    else $error("more than one result load in a cycle");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.store_byte |-> (count < plen))
    else $error("payload store written past frame length");

  a_emit_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.put_payload |-> !st.plen_zero)
    else $error("payload item from empty frame");

endmodule

`default_nettype wire

// ===== sv/slxfr_ctrl.sv =====
// ---------------------------------------------------------------------------
// slxfr_ctrl
// controller: frame hunting, payload reception and result sequencing
// ---------------------------------------------------------------------------
`default_nettype none

module slxfr_ctrl import slxfr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  rx_valid,
  output      logic  rx_stall,
  input  wire stat_t st,
  output      cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_HUNT1 = 6'b000001,
    S_HUNT2 = 6'b000010,
    S_LEN   = 6'b000100,
    S_BODY  = 6'b001000,
    S_READ  = 6'b010000,
    S_SEND  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   rx_fire;

  // byte input closed while emitting; check byte waits for a free result slot
  always_comb begin
    case (state)
      S_HUNT1, S_HUNT2, S_LEN: rx_stall = 1'b0;
      S_BODY:                  rx_stall = st.at_check && st.out_full;
      default:                 rx_stall = 1'b1;
    endcase
  end

  assign rx_fire = rx_valid && !rx_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_HUNT1: begin
        if (rx_fire && st.sync1_match) begin
          state_next = S_HUNT2;
        end
      end
      S_HUNT2: begin
        if (rx_fire) begin
          state_next = st.sync2_match ? S_LEN : S_HUNT1;
        end
      end
      S_LEN: begin
        if (rx_fire) begin
          cmd.load_len = 1'b1;
          state_next   = st.len_ok ? S_BODY : S_HUNT1;
        end
      end
      S_BODY: begin
        if (rx_fire) begin
          if (!st.at_check) begin
            cmd.store_byte = 1'b1;
          end else if (!st.check_ok) begin
            cmd.put_error = 1'b1;
            state_next    = S_HUNT1;
          end else if (st.plen_zero) begin
            cmd.put_empty = 1'b1;
            state_next    = S_HUNT1;
          end else begin
            cmd.start_emit = 1'b1;
            state_next     = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (!st.out_full) begin
          cmd.put_payload = 1'b1;
          state_next      = st.emit_last ? S_HUNT1 : S_READ;
        end
      end
      default: begin
        state_next = S_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT1;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
